// ----- rtl/tcwc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcwc_pkg
// Shared types and constants of the text cell write combiner.
// ----------------------------------------------------------------------------
package tcwc_pkg;

	localparam int COLUMNS_DEF     = 80;
	localparam int ROWS_DEF        = 25;
	localparam int FLUSH_BURST_DEF = 64;

	// Wide enough for a linear cell index at the largest screen size.
	localparam int IDX_W = 15;

	localparam logic [15:0] ATTR_MASK            = 16'hff00;
	localparam logic [7:0]  GLYPH_RESET          = 8'hdb;
	localparam logic        OUTPUT_ENABLED_RESET = 1'b1;

	localparam logic REG_OUTPUT_ENABLED = 1'b0;
	localparam logic REG_CURSOR_GLYPH   = 1'b1;

	localparam logic RK_READ  = 1'b0;
	localparam logic RK_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_READ   = 2'd1,
		KIND_CURSOR = 2'd2,
		KIND_FLUSH  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  column;
		logic [4:0]  row;
		logic [15:0] char_value;
		logic        cursor_enable;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [10:0] cell_index;
		logic [15:0] data_value;
		logic        write_valid;
		logic        more_pending;
		logic        last;
	} result_t;

	// Classified item as it waits between the front and the back.
	typedef struct packed {
		kind_t            kind;
		logic             on_screen;
		logic [IDX_W-1:0] cell_idx;
		logic [15:0]      value;
		logic             enable;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} front_out_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_status_t;

endpackage

// ----- rtl/text_cell_write_combiner.sv -----
// ----------------------------------------------------------------------------
// text_cell_write_combiner
// Write-combining shadow of a text screen with a block cursor overlay.
//
// Channel   Direction  Handshake                   Word
// item      in         item_valid / item_stall     item_t
// result    out        result_valid / result_stall result_t
// config    in         APB write/read, pready = 1  output_enabled, cursor_glyph
//
// After reset the shadow and queue marks are swept, one cell a cycle, over
// all COLUMNS*ROWS cells; items are held off during the sweep.
// In the sequencer a cursor move, and a write on the cursor cell or off
// screen, finish in the idle state; other writes read and update the stores.
// A read on the cursor cell or off screen skips the store read. A flush
// refreshes the cursor, then drains queued entries one at a time through
// the single read port of each store.
// A stalled result holds the sequencer when it has a result to emit; the
// front queue keeps taking words until its two entries are full.
// ----------------------------------------------------------------------------
module text_cell_write_combiner import tcwc_pkg::*; #(
	parameter int COLUMNS     = COLUMNS_DEF,
	parameter int ROWS        = ROWS_DEF,
	parameter int FLUSH_BURST = FLUSH_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	front_out_t   fout;
	back_status_t bstat;
	logic         out_en_q;
	logic [7:0]   glyph_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_en_q <= OUTPUT_ENABLED_RESET;
			glyph_q  <= GLYPH_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_OUTPUT_ENABLED) begin
				out_en_q <= pwdata[0];
			end else begin
				glyph_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_CURSOR_GLYPH) ? {24'h0, glyph_q} : {31'h0, out_en_q};

	tcwc_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fout       (fout),
		.bstat      (bstat)
	);

	tcwc_back #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.FLUSH_BURST (FLUSH_BURST)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fout         (fout),
		.bstat        (bstat),
		.out_en       (out_en_q),
		.glyph        (glyph_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- rtl/tcwc_front.sv -----
// ----------------------------------------------------------------------------
// tcwc_front
// Accepts items, checks the position and computes the linear cell index,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module tcwc_front import tcwc_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_t        item,
	output front_out_t   fout,
	input  back_status_t bstat
);

	entry_t     fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	entry_t     cls;
	logic       push;

	always_comb begin
		cls.kind      = kind_t'(item.kind);
		cls.on_screen = (32'(item.column) < COLUMNS) && (32'(item.row) < ROWS);
		cls.cell_idx  = IDX_W'(item.row) * IDX_W'(COLUMNS) + IDX_W'(item.column);
		cls.value     = item.char_value;
		cls.enable    = item.cursor_enable;
	end

	// No word is taken while the back end sweeps its stores after reset.
	assign item_stall = (count_q == 2'd2) || bstat.clearing;
	assign push       = item_valid && !item_stall;

	assign fout.valid = (count_q != 2'd0);
	assign fout.entry = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (bstat.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(bstat.pop);
		end
	end

endmodule

// ----- rtl/tcwc_back.sv -----
// ----------------------------------------------------------------------------
// tcwc_back
// Sequencer that carries out cell writes, reads, cursor moves and flushes
// on the shadow store and the dirty queue, with the result register.
// ----------------------------------------------------------------------------
module tcwc_back import tcwc_pkg::*; #(
	parameter int COLUMNS     = COLUMNS_DEF,
	parameter int ROWS        = ROWS_DEF,
	parameter int FLUSH_BURST = FLUSH_BURST_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  front_out_t   fout,
	output back_status_t bstat,
	input  logic         out_en,
	input  logic [7:0]   glyph,
	output logic         result_valid,
	input  logic         result_stall,
	output result_t      result
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW    = $clog2(CELLS + 1);
	localparam int BW    = $clog2(FLUSH_BURST + 1);

	typedef enum logic [13:0] {
		S_CLEAR  = 14'b00000000000001,
		S_IDLE   = 14'b00000000000010,
		S_CW_RD  = 14'b00000000000100,
		S_CW_UPD = 14'b00000000001000,
		S_CR_RD  = 14'b00000000010000,
		S_CR_PV  = 14'b00000000100000,
		S_CR_END = 14'b00000001000000,
		S_ERD    = 14'b00000010000000,
		S_RF     = 14'b00000100000000,
		S_RF2    = 14'b00001000000000,
		S_DR     = 14'b00010000000000,
		S_DQ     = 14'b00100000000000,
		S_DS     = 14'b01000000000000,
		S_DE     = 14'b10000000000000
	} state_t;

	// Stores: slot holds queue position plus one, zero when not queued.
	logic [15:0]   shadow_mem [CELLS];
	logic [SW-1:0] slot_mem   [CELLS];
	logic [15:0]   pval_mem   [CELLS];
	logic [CW-1:0] pcell_mem  [CELLS];

	logic [15:0]   sh_rd;
	logic [SW-1:0] sl_rd;
	logic [15:0]   pv_rd;
	logic [CW-1:0] pc_rd;
	logic [CW-1:0] cell_ra;
	logic [CW-1:0] pv_ra;

	logic          sh_we, sl_we, pv_we, pc_we;
	logic [CW-1:0] sh_wa, sl_wa, pv_wa;
	logic [15:0]   sh_wd, pv_wd;
	logic [SW-1:0] sl_wd;

	state_t        state_q, cw_ret_q;
	logic [CW-1:0] clr_q;
	logic [CW-1:0] head_q, tail_q;
	logic [SW-1:0] count_q;
	logic [CW-1:0] wr_idx_q, rd_idx_q, em_idx_q, dr_idx_q;
	logic [15:0]   wr_val_q, em_val_q, dr_val_q, covered_q;
	logic [SW-1:0] cr_slot_q;
	logic [15:0]   cr_shadow_q;
	logic          cr_cursor_q;
	logic [CW-1:0] target_idx_q, shown_idx_q;
	logic          target_on_q, shown_on_q;
	logic [BW-1:0] left_q;
	logic          more_q;
	logic          res_valid_q;
	result_t       res_q;

	logic          out_free, new_entry, on_cur, emit, more_c;
	logic [CW-1:0] cur_idx;
	logic [15:0]   cr_val;
	logic [BW-1:0] n_c;
	result_t       emit_data;

	function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] x);
		return (x == CW'(CELLS - 1)) ? '0 : x + 1'b1;
	endfunction

	assign out_free  = !res_valid_q || !result_stall;
	assign cur_idx   = fout.entry.cell_idx[CW-1:0];
	assign on_cur    = shown_on_q && (cur_idx == shown_idx_q);
	assign new_entry = (sl_rd == '0) && (wr_val_q != sh_rd) && (count_q != SW'(CELLS));
	assign cr_val    = (cr_slot_q != '0) ? pv_rd : cr_shadow_q;

	always_comb begin
		if (!out_en) begin
			n_c = '0;
		end else if (32'(count_q) < FLUSH_BURST) begin
			n_c = BW'(count_q);
		end else begin
			n_c = BW'(FLUSH_BURST);
		end
		more_c = (count_q != '0) && (!out_en || (32'(count_q) > FLUSH_BURST));
	end

	assign bstat.clearing = (state_q == S_CLEAR);
	assign bstat.pop      = (state_q == S_IDLE) && fout.valid;

	// Read addresses follow the state so that read data holds while waiting.
	always_comb begin
		case (state_q)
			S_CR_RD: cell_ra = rd_idx_q;
			S_DS:    cell_ra = pc_rd;
			S_DE:    cell_ra = dr_idx_q;
			default: cell_ra = wr_idx_q;
		endcase
		pv_ra = (state_q == S_CR_PV) ? CW'(sl_rd - 1'b1) : head_q;
	end

	always_comb begin
		sh_we = 1'b0;
		sh_wa = dr_idx_q;
		sh_wd = dr_val_q;
		sl_we = 1'b0;
		sl_wa = dr_idx_q;
		sl_wd = '0;
		pv_we = 1'b0;
		pv_wa = tail_q;
		pv_wd = wr_val_q;
		pc_we = 1'b0;
		case (state_q)
			S_CLEAR: begin
				sh_we = 1'b1;
				sh_wa = clr_q;
				sh_wd = '0;
				sl_we = 1'b1;
				sl_wa = clr_q;
			end
			S_CW_UPD: begin
				if (sl_rd != '0) begin
					pv_we = 1'b1;
					pv_wa = CW'(sl_rd - 1'b1);
				end else if (new_entry) begin
					pv_we = 1'b1;
					pc_we = 1'b1;
					sl_we = 1'b1;
					sl_wa = wr_idx_q;
					sl_wd = SW'(tail_q) + SW'(1);
				end
			end
			S_DE: begin
				sh_we = out_free;
				sl_we = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sh_we) begin
			shadow_mem[sh_wa] <= sh_wd;
		end
		if (sl_we) begin
			slot_mem[sl_wa] <= sl_wd;
		end
		if (pv_we) begin
			pval_mem[pv_wa] <= pv_wd;
		end
		if (pc_we) begin
			pcell_mem[tail_q] <= wr_idx_q;
		end
		sh_rd <= shadow_mem[cell_ra];
		sl_rd <= slot_mem[cell_ra];
		pv_rd <= pval_mem[pv_ra];
		pc_rd <= pcell_mem[head_q];
	end

	always_comb begin
		emit      = 1'b0;
		emit_data = '0;
		case (state_q)
			S_ERD: begin
				emit                 = out_free;
				emit_data.result_kind = RK_READ;
				emit_data.cell_index = 11'(em_idx_q);
				emit_data.data_value = em_val_q;
				emit_data.last       = 1'b1;
			end
			S_DR: begin
				emit                   = out_free && (n_c == '0);
				emit_data.result_kind  = RK_FLUSH;
				emit_data.more_pending = more_c;
				emit_data.last         = 1'b1;
			end
			S_DE: begin
				emit                   = out_free;
				emit_data.result_kind  = RK_FLUSH;
				emit_data.cell_index   = 11'(dr_idx_q);
				emit_data.data_value   = dr_val_q;
				emit_data.write_valid  = (dr_val_q != sh_rd);
				emit_data.more_pending = more_q;
				emit_data.last         = (left_q == BW'(1));
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cw_ret_q     <= S_IDLE;
			clr_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			target_idx_q <= '0;
			target_on_q  <= 1'b0;
			shown_idx_q  <= '0;
			shown_on_q   <= 1'b0;
			covered_q    <= '0;
			cr_cursor_q  <= 1'b0;
			left_q       <= '0;
			more_q       <= 1'b0;
			res_valid_q  <= 1'b0;
			wr_idx_q     <= '0;
			wr_val_q     <= '0;
			rd_idx_q     <= '0;
			em_idx_q     <= '0;
			em_val_q     <= '0;
			dr_idx_q     <= '0;
			dr_val_q     <= '0;
			cr_slot_q    <= '0;
			cr_shadow_q  <= '0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (fout.valid) begin
						case (fout.entry.kind)
							KIND_WRITE: begin
								if (fout.entry.on_screen) begin
									if (on_cur) begin
										covered_q <= fout.entry.value;
									end else begin
										wr_idx_q <= cur_idx;
										wr_val_q <= fout.entry.value;
										cw_ret_q <= S_IDLE;
										state_q  <= S_CW_RD;
									end
								end
							end
							KIND_READ: begin
								if (!fout.entry.on_screen) begin
									em_idx_q <= '0;
									em_val_q <= '0;
									state_q  <= S_ERD;
								end else if (on_cur) begin
									em_idx_q <= cur_idx;
									em_val_q <= covered_q;
									state_q  <= S_ERD;
								end else begin
									rd_idx_q    <= cur_idx;
									cr_cursor_q <= 1'b0;
									state_q     <= S_CR_RD;
								end
							end
							KIND_CURSOR: begin
								if (fout.entry.on_screen) begin
									target_idx_q <= cur_idx;
									target_on_q  <= fout.entry.enable;
								end
							end
							KIND_FLUSH: begin
								state_q <= S_RF;
							end
							default: begin
							end
						endcase
					end
				end
				S_CW_RD: begin
					state_q <= S_CW_UPD;
				end
				S_CW_UPD: begin
					if ((sl_rd == '0) && new_entry) begin
						tail_q  <= wrap_inc(tail_q);
						count_q <= count_q + 1'b1;
					end
					state_q <= cw_ret_q;
				end
				S_CR_RD: begin
					state_q <= S_CR_PV;
				end
				S_CR_PV: begin
					cr_slot_q   <= sl_rd;
					cr_shadow_q <= sh_rd;
					state_q     <= S_CR_END;
				end
				S_CR_END: begin
					if (cr_cursor_q) begin
						// Remember what the glyph hides, then draw it.
						covered_q <= cr_val;
						wr_idx_q  <= shown_idx_q;
						wr_val_q  <= (cr_val & ATTR_MASK) | {8'h00, glyph};
						cw_ret_q  <= S_DR;
						state_q   <= S_CW_RD;
					end else begin
						em_idx_q <= rd_idx_q;
						em_val_q <= cr_val;
						state_q  <= S_ERD;
					end
				end
				S_ERD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RF: begin
					if (target_on_q) begin
						if (shown_on_q) begin
							wr_idx_q <= shown_idx_q;
							wr_val_q <= covered_q;
							cw_ret_q <= S_RF2;
							state_q  <= S_CW_RD;
						end else begin
							state_q <= S_RF2;
						end
					end else if (shown_on_q) begin
						shown_on_q <= 1'b0;
						wr_idx_q   <= shown_idx_q;
						wr_val_q   <= covered_q;
						cw_ret_q   <= S_DR;
						state_q    <= S_CW_RD;
					end else begin
						state_q <= S_DR;
					end
				end
				S_RF2: begin
					shown_on_q  <= 1'b1;
					shown_idx_q <= target_idx_q;
					rd_idx_q    <= target_idx_q;
					cr_cursor_q <= 1'b1;
					state_q     <= S_CR_RD;
				end
				S_DR: begin
					left_q <= n_c;
					more_q <= more_c;
					if (n_c != '0) begin
						state_q <= S_DQ;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DQ: begin
					state_q <= S_DS;
				end
				S_DS: begin
					dr_idx_q <= pc_rd;
					dr_val_q <= pv_rd;
					state_q  <= S_DE;
				end
				S_DE: begin
					if (out_free) begin
						head_q  <= wrap_inc(head_q);
						count_q <= count_q - 1'b1;
						left_q  <= left_q - 1'b1;
						state_q <= (left_q == BW'(1)) ? S_IDLE : S_DQ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text cell write combiner: directed and random
// item words against a behavioral screen shadow, with random idling on both
// channels, a long result hold-off and register changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import tcwc_pkg::*;

	localparam int NCOL   = 80;
	localparam int NROW   = 25;
	localparam int NCELL  = NCOL * NROW;
	localparam int BURST  = 64;
	localparam int RANDOM_ITEMS = 320;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [2:0] ADDR_ENABLE = 3'd4 * REG_OUTPUT_ENABLED;
	localparam logic [2:0] ADDR_GLYPH  = 3'd4 * REG_CURSOR_GLYPH;

	// Behavioral screen shadow and result tracker.
	class screen_scoreboard;
		logic [15:0] shadow [NCELL];
		int          slot [NCELL];
		logic [15:0] pend_val [NCELL];
		int          pend_cell [NCELL];
		int          head, tail, count;
		int          tgt_col, tgt_row, shn_col, shn_row;
		bit          tgt_on, shn_on;
		logic [15:0] covered;
		bit          enabled;
		logic [7:0]  glyph;
		result_t     pending_results[$];
		int          errors, checked, flushes_drained;

		function new();
			for (int i = 0; i < NCELL; i++) begin
				shadow[i] = '0;
				slot[i] = 0;
			end
			head = 0; tail = 0; count = 0;
			tgt_col = 0; tgt_row = 0; tgt_on = 0;
			shn_col = 0; shn_row = 0; shn_on = 0;
			covered = '0; enabled = 1; glyph = GLYPH_RESET;
			errors = 0; checked = 0; flushes_drained = 0;
		endfunction

		function logic [15:0] cell_value(int idx);
			if (slot[idx] != 0) return pend_val[slot[idx] - 1];
			return shadow[idx];
		endfunction

		function void combine(int idx, logic [15:0] v);
			int q;
			if (slot[idx] == 0) begin
				if (v == shadow[idx] || count >= NCELL) return;
				q = tail;
				tail = (tail + 1) % NCELL;
				count++;
				slot[idx] = q + 1;
				pend_cell[q] = idx;
			end else begin
				q = slot[idx] - 1;
			end
			pend_val[q] = v;
		endfunction

		function void refresh_cursor();
			int idx;
			if (tgt_on) begin
				if (shn_on) combine(shn_row * NCOL + shn_col, covered);
				else shn_on = 1;
				shn_col = tgt_col;
				shn_row = tgt_row;
				idx = shn_row * NCOL + shn_col;
				covered = cell_value(idx);
				combine(idx, (covered & ATTR_MASK) | {8'h00, glyph});
			end else if (shn_on) begin
				shn_on = 0;
				combine(shn_row * NCOL + shn_col, covered);
			end
		endfunction

		function void note_item(item_t it);
			bit in_range, on_cur, more;
			int idx, n;
			result_t r;
			in_range = it.column < NCOL && it.row < NROW;
			idx = it.row * NCOL + it.column;
			on_cur = shn_on && it.column == shn_col && it.row == shn_row;
			r = '0;
			case (kind_t'(it.kind))
				KIND_WRITE: begin
					if (in_range) begin
						if (on_cur) covered = it.char_value;
						else combine(idx, it.char_value);
					end
				end
				KIND_READ: begin
					r.result_kind = RK_READ;
					r.last = 1;
					if (in_range) begin
						r.cell_index = idx[10:0];
						r.data_value = on_cur ? covered : cell_value(idx);
					end
					pending_results.push_back(r);
				end
				KIND_CURSOR: begin
					if (in_range) begin
						tgt_col = it.column;
						tgt_row = it.row;
						tgt_on = it.cursor_enable;
					end
				end
				default: begin
					refresh_cursor();
					n = enabled ? (count < BURST ? count : BURST) : 0;
					more = (count - n) != 0;
					r.result_kind = RK_FLUSH;
					r.more_pending = more;
					if (n == 0) begin
						r.last = 1;
						pending_results.push_back(r);
					end
					for (int k = 0; k < n; k++) begin
						idx = pend_cell[head];
						r.cell_index = idx[10:0];
						r.data_value = pend_val[head];
						r.write_valid = pend_val[head] != shadow[idx];
						r.last = (k + 1 == n);
						pending_results.push_back(r);
						shadow[idx] = pend_val[head];
						slot[idx] = 0;
						head = (head + 1) % NCELL;
						count--;
						flushes_drained++;
					end
				end
			endcase
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.result_kind !== want.result_kind)
				$display("%0t: result_kind expected %0d actual %0d", $time,
					want.result_kind, got.result_kind);
			if (got.cell_index !== want.cell_index)
				$display("%0t: cell_index expected %0d actual %0d", $time,
					want.cell_index, got.cell_index);
			if (got.data_value !== want.data_value)
				$display("%0t: data_value expected %h actual %h", $time,
					want.data_value, got.data_value);
			if (got.write_valid !== want.write_valid)
				$display("%0t: write_valid expected %0d actual %0d", $time,
					want.write_valid, got.write_valid);
			if (got.more_pending !== want.more_pending)
				$display("%0t: more_pending expected %0d actual %0d", $time,
					want.more_pending, got.more_pending);
			if (got.last !== want.last)
				$display("%0t: last expected %0d actual %0d", $time,
					want.last, got.last);
			if (got !== want) errors++;
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        item_valid = 0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 0;
	result_t     result;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	screen_scoreboard screen;
	longint cycles = 0;
	bit     quiet = 0;
	bit     hold_off = 0;
	int     stall_run = 0;

	text_cell_write_combiner i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: check accepted words, stall in random bursts.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) screen.check_result(result);
			if (hold_off) begin
				result_stall <= 1;
			end else if (stall_run > 0) begin
				stall_run <= stall_run - 1;
				result_stall <= 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_run <= $urandom_range(0, 11);
				result_stall <= 1;
			end else begin
				result_stall <= 0;
			end
		end
	end

	// Valid stays high after a word is taken so that the next word can follow
	// directly; end_items drops it once a sequence of words is done.
	task automatic send_item(item_t it);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			item_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1;
		item <= it;
		do @(posedge clk); while (item_stall);
		screen.note_item(it);
	endtask

	task automatic end_items();
		item_valid <= 0;
		@(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == ADDR_ENABLE) screen.enabled = data[0];
		else screen.glyph = data[7:0];
		@(posedge clk);
	endtask

	task automatic drain_results();
		end_items();
		while (screen.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic item_t make_item(logic [1:0] k, int col, int row,
			int v, int en);
		item_t it;
		it.kind = k;
		it.column = col[6:0];
		it.row = row[4:0];
		it.char_value = v[15:0];
		it.cursor_enable = en[0];
		return it;
	endfunction

	// Well-formed words mostly land on a small hot region so cells coalesce.
	function automatic item_t random_item();
		item_t it;
		int r;
		it = item_t'(31'($urandom));
		r = $urandom_range(0, 99);
		if (r < 45) it.kind = KIND_WRITE;
		else if (r < 70) it.kind = KIND_READ;
		else if (r < 82) it.kind = KIND_CURSOR;
		else it.kind = KIND_FLUSH;
		if ($urandom_range(0, 9) != 0) begin
			it.column = 7'($urandom_range(0, 7));
			it.row = 5'($urandom_range(0, 3));
		end
		if ($urandom_range(0, 3) == 0) it.char_value[15:8] = 8'h07;
		return it;
	endfunction

	task automatic flush_all();
		send_item(make_item(KIND_FLUSH, 0, 0, 0, 0));
		drain_results();
		while (screen.count != 0 && screen.enabled) begin
			send_item(make_item(KIND_FLUSH, 0, 0, 0, 0));
			drain_results();
		end
	endtask

	initial begin
		screen = new();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, every kind, out-of-range positions.
		send_item(make_item(KIND_READ, 0, 0, 0, 0));
		send_item(make_item(KIND_FLUSH, 0, 0, 0, 0));
		send_item(make_item(KIND_WRITE, 0, 0, 16'hffff, 0));
		send_item(make_item(KIND_WRITE, 79, 24, 16'h0001, 1));
		send_item(make_item(KIND_WRITE, 1, 0, 16'h0000, 0));
		send_item(make_item(KIND_WRITE, 127, 31, 16'habcd, 1));
		send_item(make_item(KIND_WRITE, 80, 0, 16'h1234, 0));
		send_item(make_item(KIND_READ, 0, 0, 0, 0));
		send_item(make_item(KIND_READ, 127, 31, 16'hffff, 1));
		send_item(make_item(KIND_READ, 0, 25, 0, 0));
		send_item(make_item(KIND_WRITE, 0, 0, 16'h0000, 0));
		send_item(make_item(KIND_CURSOR, 79, 24, 0, 1));
		send_item(make_item(KIND_CURSOR, 100, 30, 0, 0));
		send_item(make_item(KIND_FLUSH, 0, 0, 0, 0));
		send_item(make_item(KIND_WRITE, 79, 24, 16'h0741, 0));
		send_item(make_item(KIND_READ, 79, 24, 0, 0));
		send_item(make_item(KIND_CURSOR, 3, 2, 0, 1));
		send_item(make_item(KIND_FLUSH, 0, 0, 0, 0));
		send_item(make_item(KIND_CURSOR, 3, 2, 0, 0));
		send_item(make_item(KIND_FLUSH, 127, 31, 16'hffff, 1));
		drain_results();

		// More than one burst of dirty cells, with the output disabled first.
		reg_write(ADDR_ENABLE, 0);
		reg_write(ADDR_GLYPH, 32'h00);
		for (int i = 0; i < 70; i++)
			send_item(make_item(KIND_WRITE, i % NCOL, 10 + i / NCOL, i + 1, 0));
		send_item(make_item(KIND_CURSOR, 5, 10, 0, 1));
		send_item(make_item(KIND_FLUSH, 0, 0, 0, 0));
		drain_results();
		reg_write(ADDR_ENABLE, 1);
		reg_write(ADDR_GLYPH, 32'hff);

		// Long result hold-off while items keep coming.
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int i = 0; i < 40; i++)
					send_item(make_item(KIND_READ, i % NCOL, 0, 0, 0));
				end_items();
			end
		join
		@(posedge clk);
		flush_all();

		// Random phases across register settings; the last phase runs without idling.
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 3) quiet = 1;
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_item(random_item());
			drain_results();
			reg_write(ADDR_ENABLE, $urandom_range(0, 1));
			reg_write(ADDR_GLYPH, $urandom_range(0, 255));
		end
		reg_write(ADDR_ENABLE, 1);
		flush_all();
		drain_results();

		$display("Checked %0d result words, %0d drained flush entries.",
			screen.checked, screen.flushes_drained);
		if (screen.errors == 0 && screen.pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tcwc_pkg.sv
rtl/tcwc_front.sv
rtl/tcwc_back.sv
rtl/text_cell_write_combiner.sv
verif/tb.sv
